FILE: sv/per_satellite_ephemeris_table_macros.svh
// ----------------------------------------------------------------------------
// per-satellite ephemeris table: assertion macros
// shorthand for clocked assertions with reset masking
// ----------------------------------------------------------------------------
`ifndef PER_SATELLITE_EPHEMERIS_TABLE_MACROS_SVH
`define PER_SATELLITE_EPHEMERIS_TABLE_MACROS_SVH

// same-cycle implication, masked while reset is asserted
`define PSET_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked while reset is asserted
`define PSET_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/pset_pkg.sv
// ----------------------------------------------------------------------------
// pset_pkg
// shared types and codes of the per-satellite ephemeris table
// ----------------------------------------------------------------------------
package pset_pkg;

    localparam int HANDLE_W = 16;
    localparam int TIME_W   = 20;
    localparam int SAT_IN_W = 6;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 5;

    typedef enum logic [STATUS_W-1:0] {
        STAT_INSERTED  = 3'd0,
        STAT_DUPLICATE = 3'd1,
        STAT_FULL      = 3'd2,
        STAT_FOUND     = 3'd3,
        STAT_NONE      = 3'd4
    } status_t;

    typedef enum logic [0:0] {
        CMD_INSERT = 1'b0,
        CMD_QUERY  = 1'b1
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CNT,
        ST_RD,
        ST_CHK,
        ST_SHRD,
        ST_SHWR,
        ST_INS,
        ST_QFIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [TIME_W-1:0]   ref_time;
        logic [TIME_W-1:0]   clock_time;
    } rec_t;

    typedef struct packed {
        logic              dup;
        logic              ct_less;
        logic              better;
        logic [TIME_W-1:0] diff;
    } alu_res_t;

endpackage

FILE: sv/pset_rec_ram.sv
// ----------------------------------------------------------------------------
// pset_rec_ram
// record store, one write port and one registered read port
// ----------------------------------------------------------------------------
module pset_rec_ram #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  pset_pkg::rec_t      wr_data,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    output pset_pkg::rec_t      rd_data
);
    import pset_pkg::*;

    rec_t mem [DEPTH];
    rec_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/pset_cnt_ram.sv
// ----------------------------------------------------------------------------
// pset_cnt_ram
// per-satellite fill counts, valid bit per table so reset reads as zero
// ----------------------------------------------------------------------------
module pset_cnt_ram #(
    parameter int NUM_SATS = 64,
    parameter int SAT_W    = 6,
    parameter int CNT_W    = 5
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_en,
    input  logic [SAT_W-1:0] wr_addr,
    input  logic [CNT_W-1:0] wr_data,
    input  logic             rd_en,
    input  logic [SAT_W-1:0] rd_addr,
    output logic [CNT_W-1:0] rd_data
);
    logic [CNT_W-1:0]    mem [NUM_SATS];
    logic [NUM_SATS-1:0] valid_reg;
    logic [CNT_W-1:0]    rd_data_reg;
    logic                rd_valid_reg;

    // valid bits, cleared at once by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

FILE: sv/pset_alu.sv
// ----------------------------------------------------------------------------
// pset_alu
// shared compare unit: duplicate check, sort compare, time distance
// ----------------------------------------------------------------------------
module pset_alu (
    input  pset_pkg::rec_t                   entry,
    input  logic [pset_pkg::TIME_W-1:0]      item_ref_time,
    input  logic [pset_pkg::TIME_W-1:0]      item_clock_time,
    input  logic [pset_pkg::TIME_W-1:0]      query_time,
    input  logic [pset_pkg::TIME_W-1:0]      best_dist,
    input  logic                             first,
    output pset_pkg::alu_res_t               res
);
    import pset_pkg::*;

    logic [TIME_W-1:0] diff;

    // exact unsigned distance
    assign diff = (entry.ref_time >= query_time) ? (entry.ref_time - query_time)
                                                 : (query_time - entry.ref_time);

    assign res.dup     = (entry.ref_time == item_ref_time);
    assign res.ct_less = (item_clock_time < entry.clock_time);
    assign res.diff    = diff;
    // strict compare keeps the earliest entry on a tie
    assign res.better  = first || (diff < best_dist);

endmodule

FILE: sv/per_satellite_ephemeris_table.sv
// ----------------------------------------------------------------------------
// per_satellite_ephemeris_table
// per-satellite tables of ephemeris records sorted by clock time, with
// duplicate-rejecting insert and nearest-reference-time query
// ----------------------------------------------------------------------------
//
//  channel  | direction | ports
//  ---------+-----------+---------------------------------------------------
//  s_       | in        | s_valid/s_ready, cmd sat rec_handle ref_time
//           |           | clock_time query_time is_gps
//  m_       | out       | m_valid/m_ready, status found_handle
//           |           | found_ref_time slot
//
//  one word at a time; s_ready is high only while the sequencer is idle
//  query: one record ram read and one compare in the shared unit per entry;
//  rejected or empty: no scan; insert: the same scan, then one read and one
//  write per entry moved up; a duplicate stops the scan early
//  reset is synchronous; counts read as zero at once, no clearing pass
//  a result held on the m_ side lets the next word be taken and worked on;
//  it waits in the final state only if the previous result is still held
//
module per_satellite_ephemeris_table #(
    parameter int NUM_SATS        = 64,
    parameter int ENTRIES_PER_SAT = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input words
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_cmd,
    input  logic [pset_pkg::SAT_IN_W-1:0]     s_sat,
    input  logic [pset_pkg::HANDLE_W-1:0]     s_rec_handle,
    input  logic [pset_pkg::TIME_W-1:0]       s_ref_time,
    input  logic [pset_pkg::TIME_W-1:0]       s_clock_time,
    input  logic [pset_pkg::TIME_W-1:0]       s_query_time,
    input  logic                              s_is_gps,
    // result words
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [pset_pkg::STATUS_W-1:0]     m_status,
    output logic [pset_pkg::HANDLE_W-1:0]     m_found_handle,
    output logic [pset_pkg::TIME_W-1:0]       m_found_ref_time,
    output logic [pset_pkg::SLOT_W-1:0]       m_slot
);
    import pset_pkg::*;

    // derived sizes
    localparam int DEPTH  = NUM_SATS * ENTRIES_PER_SAT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SAT_W  = (NUM_SATS > 1) ? $clog2(NUM_SATS) : 1;
    localparam int CNT_W  = $clog2(ENTRIES_PER_SAT + 1);
    localparam int SX_W   = SAT_W + SAT_IN_W;
    localparam int SCMP_W = SAT_IN_W + 3;

    // sequencer
    state_t state_reg, state_next;

    // latched word
    cmd_t                cmd_reg;
    logic                gps_reg;
    logic                sat_ok_reg;
    logic [SAT_W-1:0]    sat_idx_reg;
    logic [ADDR_W-1:0]   base_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic [TIME_W-1:0]   ref_reg;
    logic [TIME_W-1:0]   clock_reg;
    logic [TIME_W-1:0]   qtime_reg;

    // scan state
    logic [CNT_W-1:0]    n_reg;
    logic [CNT_W-1:0]    idx_reg;
    logic [CNT_W-1:0]    pos_reg;
    logic                pos_found_reg;
    logic [CNT_W-1:0]    best_idx_reg;
    logic [TIME_W-1:0]   best_d_reg;
    logic [HANDLE_W-1:0] best_h_reg;
    logic [TIME_W-1:0]   best_r_reg;

    // pending result
    status_t             res_status_reg;
    logic [SLOT_W-1:0]   res_slot_reg;
    logic [HANDLE_W-1:0] res_h_reg;
    logic [TIME_W-1:0]   res_r_reg;

    // output register
    logic                m_valid_reg;
    status_t             m_status_reg;
    logic [SLOT_W-1:0]   m_slot_reg;
    logic [HANDLE_W-1:0] m_h_reg;
    logic [TIME_W-1:0]   m_r_reg;

    // word decode at the input
    logic                accept;
    logic [SX_W-1:0]     sat_ext;
    logic [SAT_W-1:0]    sat_idx;
    logic                sat_ok;
    logic [ADDR_W-1:0]   base_calc;

    // ram controls
    logic                rec_wr_en;
    logic [ADDR_W-1:0]   rec_wr_addr;
    rec_t                rec_wr_data;
    logic                rec_rd_en;
    logic [ADDR_W-1:0]   rec_rd_addr;
    rec_t                rec_rd_data;
    logic                cnt_wr_en;
    logic [CNT_W-1:0]    cnt_wr_data;
    logic                cnt_rd_data_en;
    logic [CNT_W-1:0]    cnt_rd_data;

    // scan helpers
    alu_res_t            alu;
    logic                last;
    logic                full;
    logic [CNT_W-1:0]    pos_eff;
    logic                out_free;

    assign accept    = s_valid && s_ready;
    assign sat_ext   = SX_W'(s_sat);
    assign sat_idx   = sat_ext[SAT_W-1:0];
    assign sat_ok    = SCMP_W'(s_sat) < SCMP_W'(NUM_SATS);
    assign base_calc = ADDR_W'(sat_idx) * ADDR_W'(ENTRIES_PER_SAT);

    assign last     = (idx_reg + CNT_W'(1)) == n_reg;
    assign full     = n_reg == CNT_W'(ENTRIES_PER_SAT);
    // insertion point including the entry under compare now
    assign pos_eff  = (!pos_found_reg && alu.ct_less) ? idx_reg : pos_reg;
    assign out_free = !m_valid_reg || m_ready;

    // record store
    pset_rec_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_rec_ram (
        .aclk    (aclk),
        .wr_en   (rec_wr_en),
        .wr_addr (rec_wr_addr),
        .wr_data (rec_wr_data),
        .rd_en   (rec_rd_en),
        .rd_addr (rec_rd_addr),
        .rd_data (rec_rd_data)
    );

    // fill counts
    pset_cnt_ram #(
        .NUM_SATS (NUM_SATS),
        .SAT_W    (SAT_W),
        .CNT_W    (CNT_W)
    ) u_cnt_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (cnt_wr_en),
        .wr_addr (sat_idx_reg),
        .wr_data (cnt_wr_data),
        .rd_en   (cnt_rd_data_en),
        .rd_addr (sat_idx),
        .rd_data (cnt_rd_data)
    );

    // shared compare unit, fed one stored record per check step
    pset_alu u_alu (
        .entry           (rec_rd_data),
        .item_ref_time   (ref_reg),
        .item_clock_time (clock_reg),
        .query_time      (qtime_reg),
        .best_dist       (best_d_reg),
        .first           (idx_reg == '0),
        .res             (alu)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_CNT;
                end
            end
            ST_CNT: begin
                // rejected at once: bad satellite, non-gps or empty query
                if (!sat_ok_reg ||
                    (cmd_reg == CMD_QUERY && (!gps_reg || cnt_rd_data == '0))) begin
                    state_next = ST_DONE;
                end else if (cnt_rd_data == '0) begin
                    state_next = ST_INS;
                end else begin
                    state_next = ST_RD;
                end
            end
            ST_RD: begin
                state_next = ST_CHK;
            end
            ST_CHK: begin
                if (cmd_reg == CMD_QUERY) begin
                    state_next = last ? ST_QFIN : ST_RD;
                end else if (alu.dup) begin
                    state_next = ST_DONE;
                end else if (!last) begin
                    state_next = ST_RD;
                end else if (full) begin
                    state_next = ST_DONE;
                end else if (pos_eff == n_reg) begin
                    state_next = ST_INS;
                end else begin
                    state_next = ST_SHRD;
                end
            end
            ST_SHRD: begin
                state_next = ST_SHWR;
            end
            ST_SHWR: begin
                state_next = ((idx_reg - CNT_W'(1)) == pos_reg) ? ST_INS : ST_SHRD;
            end
            ST_INS: begin
                state_next = ST_DONE;
            end
            ST_QFIN: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs: handshake and ram controls
    always_comb begin
        s_ready        = 1'b0;
        rec_wr_en      = 1'b0;
        rec_wr_addr    = base_reg + ADDR_W'(idx_reg);
        rec_wr_data    = rec_rd_data;
        rec_rd_en      = 1'b0;
        rec_rd_addr    = base_reg + ADDR_W'(idx_reg);
        cnt_wr_en      = 1'b0;
        cnt_wr_data    = n_reg + CNT_W'(1);
        cnt_rd_data_en = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready        = 1'b1;
                cnt_rd_data_en = s_valid && sat_ok;
            end
            ST_RD: begin
                rec_rd_en = 1'b1;
            end
            ST_SHRD: begin
                // fetch the entry below the slot being opened
                rec_rd_en   = 1'b1;
                rec_rd_addr = base_reg + ADDR_W'(idx_reg - CNT_W'(1));
            end
            ST_SHWR: begin
                rec_wr_en = 1'b1;
            end
            ST_INS: begin
                rec_wr_en   = 1'b1;
                rec_wr_addr = base_reg + ADDR_W'(pos_reg);
                rec_wr_data = '{handle: handle_reg, ref_time: ref_reg,
                                clock_time: clock_reg};
                cnt_wr_en   = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd_reg     <= cmd_t'(s_cmd);
                    gps_reg     <= s_is_gps;
                    sat_ok_reg  <= sat_ok;
                    sat_idx_reg <= sat_idx;
                    base_reg    <= base_calc;
                    handle_reg  <= s_rec_handle;
                    ref_reg     <= s_ref_time;
                    clock_reg   <= s_clock_time;
                    qtime_reg   <= s_query_time;
                end
            end
            ST_CNT: begin
                n_reg         <= cnt_rd_data;
                idx_reg       <= '0;
                pos_reg       <= cnt_rd_data;
                pos_found_reg <= 1'b0;
                res_slot_reg  <= '0;
                res_h_reg     <= '0;
                res_r_reg     <= '0;
                res_status_reg <= (cmd_reg == CMD_QUERY) ? STAT_NONE : STAT_FULL;
                if (sat_ok_reg && cmd_reg == CMD_INSERT && cnt_rd_data == '0) begin
                    pos_reg <= '0;
                end
            end
            ST_CHK: begin
                if (cmd_reg == CMD_QUERY) begin
                    if (alu.better) begin
                        best_idx_reg <= idx_reg;
                        best_d_reg   <= alu.diff;
                        best_h_reg   <= rec_rd_data.handle;
                        best_r_reg   <= rec_rd_data.ref_time;
                    end
                    idx_reg <= idx_reg + CNT_W'(1);
                end else if (alu.dup) begin
                    res_status_reg <= STAT_DUPLICATE;
                    res_slot_reg   <= SLOT_W'(idx_reg);
                end else begin
                    pos_reg <= pos_eff;
                    if (!pos_found_reg && alu.ct_less) begin
                        pos_found_reg <= 1'b1;
                    end
                    if (last) begin
                        // shifting starts at the top of the table
                        idx_reg <= n_reg;
                    end else begin
                        idx_reg <= idx_reg + CNT_W'(1);
                    end
                end
            end
            ST_SHWR: begin
                idx_reg <= idx_reg - CNT_W'(1);
            end
            ST_INS: begin
                res_status_reg <= STAT_INSERTED;
                res_slot_reg   <= SLOT_W'(pos_reg);
            end
            ST_QFIN: begin
                res_status_reg <= STAT_FOUND;
                res_slot_reg   <= SLOT_W'(best_idx_reg);
                res_h_reg      <= best_h_reg;
                res_r_reg      <= best_r_reg;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_status_reg <= res_status_reg;
                    m_slot_reg   <= res_slot_reg;
                    m_h_reg      <= res_h_reg;
                    m_r_reg      <= res_r_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_slot           = m_slot_reg;
    assign m_found_handle   = m_h_reg;
    assign m_found_ref_time = m_r_reg;

endmodule

FILE: sv/pset_chk.sv
// ----------------------------------------------------------------------------
// pset_chk
// port-level checks of the per-satellite ephemeris table, bound to the top
// ----------------------------------------------------------------------------
`include "per_satellite_ephemeris_table_macros.svh"

module pset_chk (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [pset_pkg::STATUS_W-1:0] m_status,
    input logic [pset_pkg::HANDLE_W-1:0] m_found_handle,
    input logic [pset_pkg::TIME_W-1:0]   m_found_ref_time,
    input logic [pset_pkg::SLOT_W-1:0]   m_slot
);
    import pset_pkg::*;

    // status codes stay within the defined set
    `PSET_ASSERT_NOW(a_status_code, m_valid, m_status == STAT_INSERTED || m_status == STAT_DUPLICATE || m_status == STAT_FULL || m_status == STAT_FOUND || m_status == STAT_NONE, "status code out of range")

    // only a found result carries a record
    `PSET_ASSERT_NOW(a_record_zero, m_valid && m_status != STAT_FOUND, m_found_handle == '0 && m_found_ref_time == '0, "record fields set on a non-found result")

    // rejected words report slot zero
    `PSET_ASSERT_NOW(a_slot_zero, m_valid && (m_status == STAT_FULL || m_status == STAT_NONE), m_slot == '0, "nonzero slot on full or none")

    // one word in flight: input closes after an accepted word
    `PSET_ASSERT_NEXT(a_one_word, s_valid && s_ready, !s_ready, "input ready right after an accepted word")

    // a stalled result holds
    `PSET_ASSERT_NEXT(a_result_hold, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_slot), "stalled result changed")

endmodule

bind per_satellite_ephemeris_table pset_chk u_pset_chk (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_status         (m_status),
    .m_found_handle   (m_found_handle),
    .m_found_ref_time (m_found_ref_time),
    .m_slot           (m_slot)
);

FILE: sim/tb_per_satellite_ephemeris_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_per_satellite_ephemeris_table
// self-checking bench for the per-satellite ephemeris table: a directed
// opening on the corner cases, then random command words grouped in phases
// around a few satellites so that tables fill, overflow and repeat reference
// times; every reply is compared against a bench-side copy of the tables
// ----------------------------------------------------------------------------

import pset_pkg::*;

typedef struct {
    status_t             status;
    logic [HANDLE_W-1:0] handle;
    logic [TIME_W-1:0]   ref_time;
    logic [SLOT_W-1:0]   slot;
} reply_t;

// shadow of the tables plus the queue of replies still owed by the block
class ephem_table_tracker;
    localparam int SATS  = 64;
    localparam int DEPTH = 16;

    int unsigned         fill_level [SATS];
    logic [HANDLE_W-1:0] handle_mem [SATS*DEPTH];
    logic [TIME_W-1:0]   ref_mem    [SATS*DEPTH];
    logic [TIME_W-1:0]   clock_mem  [SATS*DEPTH];
    reply_t              owed_replies [$];
    int                  errors;

    function new();
        foreach (fill_level[i]) fill_level[i] = 0;
        errors = 0;
    endfunction

    function int pending();
        return owed_replies.size();
    endfunction

    // sorted insert with duplicate and overflow rejection
    function reply_t insert_record(int sat, logic [HANDLE_W-1:0] h,
                                   logic [TIME_W-1:0] rt, logic [TIME_W-1:0] ct);
        int     base;
        int     n;
        int     pos;
        reply_t r;
        r.status   = STAT_INSERTED;
        r.handle   = '0;
        r.ref_time = '0;
        r.slot     = '0;
        base = sat * DEPTH;
        n    = fill_level[sat];
        for (int i = 0; i < n; i++) begin
            if (ref_mem[base+i] == rt) begin
                r.status = STAT_DUPLICATE;
                r.slot   = SLOT_W'(i);
                return r;
            end
        end
        if (n >= DEPTH) begin
            r.status = STAT_FULL;
            return r;
        end
        pos = n;
        for (int i = 0; i < n; i++) begin
            if (ct < clock_mem[base+i]) begin
                pos = i;
                break;
            end
        end
        for (int i = n; i > pos; i--) begin
            handle_mem[base+i] = handle_mem[base+i-1];
            ref_mem[base+i]    = ref_mem[base+i-1];
            clock_mem[base+i]  = clock_mem[base+i-1];
        end
        handle_mem[base+pos] = h;
        ref_mem[base+pos]    = rt;
        clock_mem[base+pos]  = ct;
        fill_level[sat]      = n + 1;
        r.slot = SLOT_W'(pos);
        return r;
    endfunction

    // nearest reference time, earliest entry wins a tie
    function reply_t nearest_record(int sat, logic [TIME_W-1:0] qt, logic gps);
        int                base;
        int                n;
        int                best;
        logic [TIME_W-1:0] best_dist;
        logic [TIME_W-1:0] diff;
        logic [TIME_W-1:0] r_t;
        reply_t            r;
        r.status   = STAT_NONE;
        r.handle   = '0;
        r.ref_time = '0;
        r.slot     = '0;
        base = sat * DEPTH;
        n    = fill_level[sat];
        if (!gps || n == 0) return r;
        best      = 0;
        best_dist = '0;
        for (int i = 0; i < n; i++) begin
            r_t  = ref_mem[base+i];
            diff = (r_t >= qt) ? r_t - qt : qt - r_t;
            if (i == 0 || diff < best_dist) begin
                best      = i;
                best_dist = diff;
            end
        end
        r.status   = STAT_FOUND;
        r.handle   = handle_mem[base+best];
        r.ref_time = ref_mem[base+best];
        r.slot     = SLOT_W'(best);
        return r;
    endfunction

    function void take_command(cmd_t cmd, logic [SAT_IN_W-1:0] sat,
                               logic [HANDLE_W-1:0] h, logic [TIME_W-1:0] rt,
                               logic [TIME_W-1:0] ct, logic [TIME_W-1:0] qt,
                               logic gps);
        if (cmd == CMD_INSERT)
            owed_replies = {owed_replies, insert_record(int'(sat), h, rt, ct)};
        else
            owed_replies = {owed_replies, nearest_record(int'(sat), qt, gps)};
    endfunction

    function void check_reply(logic [STATUS_W-1:0] status, logic [HANDLE_W-1:0] h,
                              logic [TIME_W-1:0] rt, logic [SLOT_W-1:0] slot);
        reply_t want;
        if (owed_replies.size() == 0) begin
            errors++;
            $display("%0t: reply with no command outstanding, status %0d",
                     $time, status);
            return;
        end
        want = owed_replies.pop_front();
        if (status !== want.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, want.status, status);
        end
        if (h !== want.handle) begin
            errors++;
            $display("%0t: found_handle expected %0h actual %0h", $time, want.handle, h);
        end
        if (rt !== want.ref_time) begin
            errors++;
            $display("%0t: found_ref_time expected %0d actual %0d",
                     $time, want.ref_time, rt);
        end
        if (slot !== want.slot) begin
            errors++;
            $display("%0t: slot expected %0d actual %0d", $time, want.slot, slot);
        end
    endfunction
endclass

module tb_per_satellite_ephemeris_table;

    localparam logic [TIME_W-1:0] WEEK_END = 20'd604799;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic                s_cmd;
    logic [SAT_IN_W-1:0] s_sat;
    logic [HANDLE_W-1:0] s_rec_handle;
    logic [TIME_W-1:0]   s_ref_time;
    logic [TIME_W-1:0]   s_clock_time;
    logic [TIME_W-1:0]   s_query_time;
    logic                s_is_gps;
    logic                m_valid;
    logic                m_ready;
    logic [STATUS_W-1:0] m_status;
    logic [HANDLE_W-1:0] m_found_handle;
    logic [TIME_W-1:0]   m_found_ref_time;
    logic [SLOT_W-1:0]   m_slot;

    ephem_table_tracker tracker;

    // set during quiet phases: neither side idles nor stalls
    bit no_idle = 1'b0;
    int ready_hold = 0;

    per_satellite_ephemeris_table uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_sat            (s_sat),
        .s_rec_handle     (s_rec_handle),
        .s_ref_time       (s_ref_time),
        .s_clock_time     (s_clock_time),
        .s_query_time     (s_query_time),
        .s_is_gps         (s_is_gps),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_found_handle   (m_found_handle),
        .m_found_ref_time (m_found_ref_time),
        .m_slot           (m_slot)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // present one command word and hold it until the block takes it;
    // the handshake is judged at the falling edge, where both sides are settled
    task automatic send_word(cmd_t cmd, logic [SAT_IN_W-1:0] sat,
                             logic [HANDLE_W-1:0] h, logic [TIME_W-1:0] rt,
                             logic [TIME_W-1:0] ct, logic [TIME_W-1:0] qt,
                             logic gps);
        int gap;
        bit taken;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_cmd        <= cmd;
        s_sat        <= sat;
        s_rec_handle <= h;
        s_ref_time   <= rt;
        s_clock_time <= ct;
        s_query_time <= qt;
        s_is_gps     <= gps;
        do begin
            @(negedge aclk);
            taken = (s_ready === 1'b1);
            @(posedge aclk);
        end while (!taken);
        tracker.take_command(cmd, sat, h, rt, ct, qt, gps);
    endtask

    // hold back until every owed reply is back, always moving on a cycle
    task automatic drain_replies();
        s_valid <= 1'b0;
        do @(posedge aclk); while (tracker.pending() != 0);
    endtask

    // receiver: runs of ready broken by stalls of random length
    always @(posedge aclk) begin
        if (no_idle) begin
            m_ready    <= 1'b1;
            ready_hold <= 0;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if ($urandom_range(0, 1) == 0) begin
            m_ready    <= 1'b1;
            ready_hold <= $urandom_range(0, 15);
        end else begin
            m_ready    <= 1'b0;
            ready_hold <= pick_gap();
        end
    end

    // result monitor, sampled at the falling edge ahead of the accepting edge
    always @(negedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready === 1'b1)
            tracker.check_reply(m_status, m_found_handle, m_found_ref_time, m_slot);
    end

    initial begin
        int                  pool_base;
        int                  pool_size;
        int                  r;
        cmd_t                cmd;
        logic [SAT_IN_W-1:0] sat;
        logic [TIME_W-1:0]   rt;
        logic [TIME_W-1:0]   ct;
        logic [TIME_W-1:0]   qt;

        tracker = new();
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_cmd        <= CMD_INSERT;
        s_sat        <= '0;
        s_rec_handle <= '0;
        s_ref_time   <= '0;
        s_clock_time <= '0;
        s_query_time <= '0;
        s_is_gps     <= 1'b0;
        m_ready      <= 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // --- directed opening ---
        // query on an empty table
        send_word(CMD_QUERY, 6'd5, 16'h0, 20'd0, 20'd0, 20'd100, 1'b1);
        // extremes of handle, reference and clock time
        send_word(CMD_INSERT, 6'd5, 16'h0000, 20'd0, WEEK_END, 20'd0, 1'b0);
        send_word(CMD_INSERT, 6'd5, 16'hffff, WEEK_END, 20'd0, WEEK_END, 1'b1);
        // equal clock time lands after the existing one
        send_word(CMD_INSERT, 6'd5, 16'h1234, 20'd2000, 20'd0, 20'd0, 1'b0);
        // repeated reference time is turned away
        send_word(CMD_INSERT, 6'd5, 16'h5555, 20'd2000, 20'd77, 20'd0, 1'b0);
        // equidistant from 0 and 2000: earlier entry in table order wins
        send_word(CMD_QUERY, 6'd5, 16'h0, 20'd0, 20'd0, 20'd1000, 1'b1);
        // non-gps query finds nothing even with entries present
        send_word(CMD_QUERY, 6'd5, 16'h0, 20'd0, 20'd0, 20'd1000, 1'b0);
        // fill the top satellite with falling clock times so every insert
        // goes to the front and moves the whole table up
        for (int i = 0; i < 16; i++)
            send_word(CMD_INSERT, 6'd63, 16'(i), 20'(i * 100 + 50),
                      WEEK_END - 20'(i), 20'd0, 1'b0);
        // overflow, then a duplicate on a full table
        send_word(CMD_INSERT, 6'd63, 16'haaaa, 20'd604000, 20'd0, 20'd0, 1'b0);
        send_word(CMD_INSERT, 6'd63, 16'hbbbb, 20'd550, 20'd0, 20'd0, 1'b0);
        drain_replies();

        // --- random phases ---
        // each phase works a small pool of satellites so tables fill up and
        // reference times repeat; times sit on a grid so queries can tie
        for (int phase = 0; phase < 8; phase++) begin
            no_idle   = (phase == 2 || phase == 5);
            pool_base = $urandom_range(0, 63);
            pool_size = $urandom_range(2, 6);
            for (int k = 0; k < 250; k++) begin
                cmd = ($urandom_range(0, 99) < 55) ? CMD_INSERT : CMD_QUERY;
                if ($urandom_range(0, 99) < 85)
                    sat = SAT_IN_W'((pool_base + $urandom_range(0, pool_size - 1)) % 64);
                else
                    sat = SAT_IN_W'($urandom_range(0, 63));
                r = $urandom_range(0, 99);
                if (r < 60)      rt = 20'($urandom_range(0, 24) * 100);
                else if (r < 90) rt = 20'($urandom_range(0, 604799));
                else if (r < 95) rt = 20'd0;
                else             rt = WEEK_END;
                // few distinct clock times so equal ones are common
                if ($urandom_range(0, 1) == 0) ct = 20'($urandom_range(0, 7));
                else                           ct = 20'($urandom_range(0, 604799));
                r = $urandom_range(0, 99);
                if (r < 50)      qt = 20'($urandom_range(0, 50) * 50);
                else if (r < 80) qt = 20'($urandom_range(0, 604799));
                else if (r < 90) qt = 20'd0;
                else             qt = WEEK_END;
                send_word(cmd, sat, 16'($urandom_range(0, 65535)), rt, ct, qt,
                          ($urandom_range(0, 9) != 0));
            end
            // sender holds off until the block has answered everything
            drain_replies();
        end
        no_idle = 1'b0;

        // tail: catch any stray reply
        repeat (80) @(posedge aclk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // watchdog well beyond the slowest legal run
    initial begin
        #8000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
